[sv/cme_pkg.sv]
// Shared types, constants and the CORDIC angle table for the cylinder mesh
// element generator. No dependencies.
package cme_pkg;

  // defaults for the top-level parameters
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int INDEX_BITS_DEF   = 16;

  // segment count limits
  localparam logic [13:0] N_MIN        = 14'd3;
  localparam logic [13:0] N_MAX_SMOOTH = 14'd16382;
  localparam logic [13:0] N_MAX_FLAT   = 14'd10922;

  // request opcodes
  localparam logic OP_VERTEX   = 1'b0;
  localparam logic OP_TRIANGLE = 1'b1;

  // register indexes
  localparam logic [1:0] REG_SEGMENTS = 2'd0;
  localparam logic [1:0] REG_LENGTH   = 2'd1;
  localparam logic [1:0] REG_SMOOTH   = 2'd2;

  // phase divider: 32 quotient bits, divisor and remainder below 2^15
  localparam int DIV_BITS = 32;
  localparam int DW       = 15;

  // CORDIC datapath width (Q2.30 plus headroom)
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

  localparam logic signed [15:0] ONE_Q14  = 16'sd16384;
  localparam logic signed [14:0] HALF_Q14 = 15'sd8192;

  // atan(2^-i) in turns * 2^-32
  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:  a = 34'sd536870912;
      1:  a = 34'sd316933406;
      2:  a = 34'sd167458907;
      3:  a = 34'sd85004756;
      4:  a = 34'sd42667331;
      5:  a = 34'sd21354465;
      6:  a = 34'sd10679838;
      7:  a = 34'sd5340245;
      8:  a = 34'sd2670163;
      9:  a = 34'sd1335087;
      10: a = 34'sd667544;
      11: a = 34'sd333772;
      12: a = 34'sd166886;
      13: a = 34'sd83443;
      14: a = 34'sd41722;
      15: a = 34'sd20861;
      16: a = 34'sd10430;
      17: a = 34'sd5215;
      18: a = 34'sd2608;
      19: a = 34'sd1304;
      20: a = 34'sd652;
      21: a = 34'sd326;
      22: a = 34'sd163;
      23: a = 34'sd81;
      default: a = '0;
    endcase
    return a;
  endfunction

  // classified request, handed from front to back
  typedef struct packed {
    logic                 oor;
    logic                 pos_zero;     // center vertex, triangle or error
    logic                 nxz_zero;     // cap, triangle or error
    logic                 norm_from_a;  // flat side: normal from mid phase
    logic signed [15:0]   py;
    logic signed [15:0]   ny;
    logic [15:0]          corner_a;
    logic [15:0]          corner_b;
    logic [15:0]          corner_c;
    logic [DW-1:0]        num_a;        // mid phase numerator
    logic [DW-1:0]        den_a;
    logic [DW-1:0]        num_b;        // point phase numerator
    logic [DW-1:0]        den_b;
  } job_t;

endpackage

[sv/cylinder_mesh_element_generator.sv]
// Cylinder mesh element generator: vertex and triangle requests in, one
// result beat per request out. Uses cme_pkg, cme_front, cme_fifo, cme_back.
//
// Usage:
//   Config: cfg_valid_i/cfg_ready_o with cfg_index_i (0 segment count,
//   1 length Q8.8, 2 smooth mode) and cfg_data_i. Always ready; write only
//   while no request is in flight.
//   Requests: in_valid_i/in_stall_o carry opcode_i (vertex or triangle) and
//   element_number_i. Results: out_valid_o/out_stall_i carry position,
//   normal, triangle corners and out_of_range_o.
//   Throughput: one beat per cycle while out_stall_i is low. A request
//   passes through the job queue, the 33 divider registers, the
//   CORDIC_STEPS + 1 rotator registers and the output register before
//   out_valid_o rises.
//   Reset clears the pipeline and loads N = 16, length 1.0, smooth mode.
//   A stalled output freezes the back-end pipeline; the 4-entry job queue
//   keeps taking beats until it fills, then in_stall_o rises.
module cylinder_mesh_element_generator import cme_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
  parameter int INDEX_BITS   = INDEX_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [15:0]        element_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [14:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [15:0]        corner_a_o,
  output logic [15:0]        corner_b_o,
  output logic [15:0]        corner_c_o,
  output logic               out_of_range_o
);

  logic [13:0] seg_q;
  logic [15:0] len_q;
  logic        smooth_q;
  job_t        job_in, job_out;
  logic        full, empty, pop, push;

  assign cfg_ready_o = 1'b1;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q    <= 14'd16;
      len_q    <= 16'd256;
      smooth_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_SEGMENTS: seg_q    <= cfg_data_i[13:0];
        REG_LENGTH:   len_q    <= cfg_data_i;
        REG_SMOOTH:   smooth_q <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign in_stall_o = full;
  assign push       = in_valid_i && !full;

  cme_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .segment_count_i  (seg_q),
    .length_q8_i      (len_q),
    .smooth_mode_i    (smooth_q),
    .opcode_i         (opcode_i),
    .element_number_i (element_number_i),
    .job_o            (job_in)
  );

  cme_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (job_out)
  );

  cme_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (!empty),
    .job_i          (job_out),
    .job_pop_o      (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .norm_x_o       (norm_x_o),
    .norm_y_o       (norm_y_o),
    .norm_z_o       (norm_z_o),
    .corner_a_o     (corner_a_o),
    .corner_b_o     (corner_b_o),
    .corner_c_o     (corner_c_o),
    .out_of_range_o (out_of_range_o)
  );

endmodule

[sv/cme_front.sv]
// Front end: clamps the segment count and classifies one request into a job.
// Depends on cme_pkg.
module cme_front import cme_pkg::*; #(
  parameter int INDEX_BITS = INDEX_BITS_DEF
) (
  input  logic [13:0] segment_count_i,
  input  logic [15:0] length_q8_i,
  input  logic        smooth_mode_i,
  input  logic        opcode_i,
  input  logic [15:0] element_number_i,
  output job_t        job_o
);

  localparam logic [15:0] IDX_MASK = (INDEX_BITS >= 16) ? 16'hFFFF :
                                     16'((33'd1 << INDEX_BITS) - 33'd1);

  logic [13:0] n;
  logic [17:0] n18, e18, side, bc, cnt_v, cnt_t, seg, base, center, sb, ca, cb, cc;
  logic        bottom;
  logic signed [15:0] h;

  // effective segment count
  always_comb begin
    n = segment_count_i;
    if (n < N_MIN) n = N_MIN;
    if (smooth_mode_i && n > N_MAX_SMOOTH) n = N_MAX_SMOOTH;
    if (!smooth_mode_i && n > N_MAX_FLAT) n = N_MAX_FLAT;
  end

  assign n18   = 18'(n);
  assign e18   = 18'(element_number_i);
  assign side  = smooth_mode_i ? (n18 << 1) + 18'd2 : (n18 << 2);
  assign bc    = side + n18 + 18'd2;
  assign cnt_v = bc + n18 + 18'd2;
  assign cnt_t = n18 << 2;
  assign h     = 16'(length_q8_i >> 1);

  // classification
  always_comb begin
    job_o       = '0;
    seg         = '0;
    base        = '0;
    center      = '0;
    sb          = '0;
    ca          = '0;
    cb          = '0;
    cc          = '0;
    bottom      = 1'b0;
    job_o.pos_zero = 1'b1;
    job_o.nxz_zero = 1'b1;
    job_o.den_a    = DW'(n18);
    job_o.den_b    = DW'(n18);
    if (opcode_i == OP_VERTEX) begin
      if (e18 >= cnt_v) begin
        job_o.oor = 1'b1;
      end else if (e18 < side) begin
        job_o.pos_zero = 1'b0;
        job_o.nxz_zero = 1'b0;
        bottom = e18[0];
        if (smooth_mode_i) begin
          seg = e18 >> 1;
          sb  = seg;
        end else begin
          seg = e18 >> 2;
          sb  = seg + 18'(e18[1]);
          job_o.norm_from_a = 1'b1;
          job_o.num_a = DW'((seg << 1) + 18'd1);
          job_o.den_a = DW'(n18 << 1);
        end
        job_o.py = bottom ? -h : h;
      end else begin
        bottom = (e18 >= bc);
        center = bottom ? bc : side;
        job_o.pos_zero = (e18 == center);
        sb = e18 - center - 18'd1;
        job_o.py = bottom ? -h : h;
        job_o.ny = bottom ? -ONE_Q14 : ONE_Q14;
      end
      // point s = N wraps to phase zero
      job_o.num_b = (sb == n18) ? '0 : DW'(sb);
    end else begin
      if (e18 >= cnt_t) begin
        job_o.oor = 1'b1;
      end else begin
        if (e18 < (n18 << 1)) begin
          seg  = e18 >> 1;
          base = smooth_mode_i ? (seg << 1) : (seg << 2);
          if (!e18[0]) begin
            ca = base; cb = base + 18'd2; cc = base + 18'd1;
          end else begin
            ca = base + 18'd1; cb = base + 18'd2; cc = base + 18'd3;
          end
        end else if (e18 < (n18 << 1) + n18) begin
          seg = e18 - (n18 << 1);
          ca = side; cb = side + 18'd2 + seg; cc = side + 18'd1 + seg;
        end else begin
          seg = e18 - (n18 << 1) - n18;
          ca = bc; cb = bc + 18'd1 + seg; cc = bc + 18'd2 + seg;
        end
        job_o.corner_a = ca[15:0] & IDX_MASK;
        job_o.corner_b = cb[15:0] & IDX_MASK;
        job_o.corner_c = cc[15:0] & IDX_MASK;
      end
    end
  end

endmodule

[sv/cme_fifo.sv]
// Short job queue between front and back end.
// Depends on cme_pkg.
module cme_fifo import cme_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t rdata_o
);

  localparam int DEPTH = 4;

  job_t       mem [DEPTH];
  logic [1:0] wr_q, wr_d, rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 3'(DEPTH));
  assign empty_o = (cnt_q == 3'd0);
  assign rdata_o = mem[rd_q];

  // pointer and fill update
  always_comb begin
    wr_d  = wr_q + 2'(push_i);
    rd_d  = rd_q + 2'(pop_i);
    cnt_d = cnt_q + 3'(push_i) - 3'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem[wr_q] <= wdata_i;
  end

endmodule

[sv/cme_back.sv]
// Back end: pipelined phase dividers, two CORDIC rotators, rounding and the
// output register. Depends on cme_pkg.
module cme_back import cme_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  job_t               job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [14:0] pos_x_o,
  output logic signed [15:0] pos_y_o,
  output logic signed [14:0] pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic signed [15:0] norm_z_o,
  output logic [15:0]        corner_a_o,
  output logic [15:0]        corner_b_o,
  output logic [15:0]        corner_c_o,
  output logic               out_of_range_o
);

  typedef struct packed {
    job_t                job;
    logic [DW-1:0]       rem_a;
    logic [DW-1:0]       rem_b;
    logic [DIV_BITS-1:0] quo_a;
    logic [DIV_BITS-1:0] quo_b;
  } div_t;

  typedef struct packed {
    job_t                job;
    logic                flip_a;
    logic                flip_b;
    logic signed [CW-1:0] xa, ya, za;
    logic signed [CW-1:0] xb, yb, zb;
  } rot_t;

  logic adv;
  div_t div_q [DIV_BITS+1];
  logic div_v_q [DIV_BITS+1];
  rot_t rot_q [CORDIC_STEPS+1];
  logic rot_v_q [CORDIC_STEPS+1];
  logic out_valid_q;

  // whole pipeline moves when the output register can take a beat
  assign adv       = !out_valid_q || !out_stall_i;
  assign job_pop_o = adv && job_valid_i;
  assign out_valid_o = out_valid_q;

  // one restoring division step: returns {quotient bit, remainder}
  function automatic logic [DW:0] div_step(input logic [DW-1:0] r,
                                           input logic [DW-1:0] d,
                                           input logic b);
    logic [DW:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) return {1'b1, DW'(t - {1'b0, d})};
    return {1'b0, r[DW-2:0], b};
  endfunction

  // rotator start: fold phase into +-1/4 turn
  function automatic logic [CW:0] fold(input logic [31:0] ph);
    logic        flip;
    logic [31:0] p, t;
    t    = ph - TURN_QUARTER;
    flip = !t[31];
    p    = flip ? {~ph[31], ph[30:0]} : ph;
    return {flip, CW'(signed'(p))};
  endfunction

  function automatic logic signed [15:0] rnd_norm(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + 34'sd32768) >>> 16;
    if (r > 34'sd16384) r = 34'sd16384;
    if (r < -34'sd16384) r = -34'sd16384;
    return 16'(r);
  endfunction

  function automatic logic signed [14:0] rnd_pos(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + 34'sd65536) >>> 17;
    if (r > 34'sd8192) r = 34'sd8192;
    if (r < -34'sd8192) r = -34'sd8192;
    return 15'(r);
  endfunction

  // load from the queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_v_q[0] <= 1'b0;
    end else if (adv) begin
      div_v_q[0] <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      div_q[0].job   <= job_i;
      div_q[0].rem_a <= job_i.num_a;
      div_q[0].rem_b <= job_i.num_b;
      div_q[0].quo_a <= '0;
      div_q[0].quo_b <= '0;
    end
  end

  // divider stages, one quotient bit each
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    logic [DIV_BITS-1:0] low_a, low_b;
    logic [DW:0]         sa, sb;
    div_t                nxt;

    always_comb begin
      low_a = DIV_BITS'(div_q[k].job.den_a >> 1);
      low_b = DIV_BITS'(div_q[k].job.den_b >> 1);
      sa    = div_step(div_q[k].rem_a, div_q[k].job.den_a, low_a[B]);
      sb    = div_step(div_q[k].rem_b, div_q[k].job.den_b, low_b[B]);
      nxt          = div_q[k];
      nxt.rem_a    = sa[DW-1:0];
      nxt.rem_b    = sb[DW-1:0];
      nxt.quo_a[B] = sa[DW];
      nxt.quo_b[B] = sb[DW];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        div_v_q[k+1] <= div_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) div_q[k+1] <= nxt;
    end
  end

  // rotator entry
  logic [CW:0] fa, fb;
  assign fa = fold(div_q[DIV_BITS].quo_a);
  assign fb = fold(div_q[DIV_BITS].quo_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_v_q[0] <= 1'b0;
    end else if (adv) begin
      rot_v_q[0] <= div_v_q[DIV_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rot_q[0].job    <= div_q[DIV_BITS].job;
      rot_q[0].flip_a <= fa[CW];
      rot_q[0].flip_b <= fb[CW];
      rot_q[0].xa     <= CORDIC_GAIN;
      rot_q[0].ya     <= '0;
      rot_q[0].za     <= signed'(fa[CW-1:0]);
      rot_q[0].xb     <= CORDIC_GAIN;
      rot_q[0].yb     <= '0;
      rot_q[0].zb     <= signed'(fb[CW-1:0]);
    end
  end

  // CORDIC micro-rotations
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    rot_t nxt;
    logic signed [CW-1:0] at;

    always_comb begin
      at  = atan_turn(i);
      nxt = rot_q[i];
      if (!rot_q[i].za[CW-1]) begin
        nxt.xa = rot_q[i].xa - (rot_q[i].ya >>> i);
        nxt.ya = rot_q[i].ya + (rot_q[i].xa >>> i);
        nxt.za = rot_q[i].za - at;
      end else begin
        nxt.xa = rot_q[i].xa + (rot_q[i].ya >>> i);
        nxt.ya = rot_q[i].ya - (rot_q[i].xa >>> i);
        nxt.za = rot_q[i].za + at;
      end
      if (!rot_q[i].zb[CW-1]) begin
        nxt.xb = rot_q[i].xb - (rot_q[i].yb >>> i);
        nxt.yb = rot_q[i].yb + (rot_q[i].xb >>> i);
        nxt.zb = rot_q[i].zb - at;
      end else begin
        nxt.xb = rot_q[i].xb + (rot_q[i].yb >>> i);
        nxt.yb = rot_q[i].yb - (rot_q[i].xb >>> i);
        nxt.zb = rot_q[i].zb + at;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        rot_v_q[i+1] <= 1'b0;
      end else if (adv) begin
        rot_v_q[i+1] <= rot_v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) rot_q[i+1] <= nxt;
    end
  end

  // unfold, round and select
  rot_t                 fin;
  logic signed [CW-1:0] ca, sa, cb, sb, cn, sn;
  logic signed [14:0]   pos_x_d, pos_z_d;
  logic signed [15:0]   norm_x_d, norm_z_d;

  always_comb begin
    fin = rot_q[CORDIC_STEPS];
    ca  = fin.flip_a ? -fin.xa : fin.xa;
    sa  = fin.flip_a ? -fin.ya : fin.ya;
    cb  = fin.flip_b ? -fin.xb : fin.xb;
    sb  = fin.flip_b ? -fin.yb : fin.yb;
    cn  = fin.job.norm_from_a ? ca : cb;
    sn  = fin.job.norm_from_a ? sa : sb;
    pos_x_d  = fin.job.pos_zero ? '0 : rnd_pos(cb);
    pos_z_d  = fin.job.pos_zero ? '0 : rnd_pos(sb);
    norm_x_d = fin.job.nxz_zero ? '0 : rnd_norm(cn);
    norm_z_d = fin.job.nxz_zero ? '0 : rnd_norm(sn);
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= rot_v_q[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pos_x_o        <= pos_x_d;
      pos_y_o        <= fin.job.py;
      pos_z_o        <= pos_z_d;
      norm_x_o       <= norm_x_d;
      norm_y_o       <= fin.job.ny;
      norm_z_o       <= norm_z_d;
      corner_a_o     <= fin.job.corner_a;
      corner_b_o     <= fin.job.corner_b;
      corner_c_o     <= fin.job.corner_c;
      out_of_range_o <= fin.job.oor;
    end
  end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for cylinder_mesh_element_generator: vertex and triangle
// requests are compared against a behavioral CORDIC mesh predictor. Uses cme_pkg.
module tb_top;
  import cme_pkg::*;

  localparam int STEPS     = 16;
  localparam int LATENCY   = STEPS + 36;
  localparam int MAX_CYC   = 400000;
  localparam int N_RANDOM  = 900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic opcode_i = OP_VERTEX;
  logic [15:0] element_number_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [14:0] pos_x_o, pos_z_o;
  logic signed [15:0] pos_y_o, norm_x_o, norm_y_o, norm_z_o;
  logic [15:0] corner_a_o, corner_b_o, corner_c_o;
  logic out_of_range_o;

  cylinder_mesh_element_generator dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  typedef struct packed {
    logic [14:0] px;
    logic [15:0] py;
    logic [14:0] pz;
    logic [15:0] nx, ny, nz;
    logic [15:0] ca, cb, cc;
    logic        oor;
  } elem_t;

  // predictor copy of the registers
  logic [13:0] seg_reg = 14'd16;
  logic [15:0] len_reg = 16'd256;
  logic        smooth_reg = 1'b1;

  elem_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int n_vert = 0, n_tri = 0, n_oor = 0;
  logic quiet = 1'b0;     // no idling in the last stretch
  logic hold_long = 1'b0; // long receiver hold-off request

  function automatic longint floor_sh(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint rnd_sat(longint v, int k, longint lim);
    longint r;
    r = (v + (longint'(1) << (k - 1))) >>> k;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  // rotate from the gain constant to the given phase (turns * 2^-32)
  task automatic rotate(input logic [31:0] phase, output longint c, output longint s);
    logic [31:0] p, t;
    logic flip;
    longint z, x, y, dx, dy, a;
    t = phase - TURN_QUARTER;
    flip = t < 32'h8000_0000;
    p = flip ? phase - 32'h8000_0000 : phase;
    z = p[31] ? longint'(p) - (longint'(1) << 32) : longint'(p);
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = floor_sh(y, i);
      dy = floor_sh(x, i);
      a = longint'(atan_turn(i));
      if (z >= 0) begin
        x -= dx; y += dy; z -= a;
      end else begin
        x += dx; y -= dy; z += a;
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic logic [31:0] pt_phase(longint s, longint n);
    return 32'(((s << 32) + n / 2) / n);
  endfunction

  function automatic logic [31:0] md_phase(longint s, longint n);
    return 32'((((2 * s + 1) << 32) + n) / (2 * n));
  endfunction

  function automatic int eff_segments();
    int n;
    n = seg_reg;
    if (n < 3) n = 3;
    if (smooth_reg && n > 16382) n = 16382;
    if (!smooth_reg && n > 10922) n = 10922;
    return n;
  endfunction

  task automatic predict_element(input logic op, input logic [15:0] num, output elem_t r);
    int n, e, side, tc, bc, seg, sub, base, a, b, cc;
    longint h, c, s;
    logic bottom;
    n = eff_segments();
    e = num;
    side = smooth_reg ? 2 * n + 2 : 4 * n;
    tc = side;
    bc = tc + n + 2;
    h = len_reg >> 1;
    r = '0;
    if (op == OP_VERTEX) begin
      if (e >= bc + n + 2) begin
        r.oor = 1'b1;
        return;
      end
      if (e < side) begin
        if (smooth_reg) begin
          seg = e >> 1; bottom = e[0];
          rotate(pt_phase(seg, n), c, s);
          r.nx = 16'(rnd_sat(c, 16, 16384));
          r.nz = 16'(rnd_sat(s, 16, 16384));
        end else begin
          seg = e >> 2; sub = e & 3; bottom = sub[0];
          rotate(md_phase(seg, n), c, s);
          r.nx = 16'(rnd_sat(c, 16, 16384));
          r.nz = 16'(rnd_sat(s, 16, 16384));
          if (sub[1]) seg++;
          rotate(pt_phase(seg, n), c, s);
        end
        r.px = 15'(rnd_sat(c, 17, 8192));
        r.pz = 15'(rnd_sat(s, 17, 8192));
        r.py = 16'(bottom ? -h : h);
      end else begin
        bottom = e >= bc;
        r.py = 16'(bottom ? -h : h);
        r.ny = bottom ? -16'sd16384 : 16'sd16384;
        if (e != (bottom ? bc : tc)) begin
          rotate(pt_phase(e - (bottom ? bc : tc) - 1, n), c, s);
          r.px = 15'(rnd_sat(c, 17, 8192));
          r.pz = 15'(rnd_sat(s, 17, 8192));
        end
      end
    end else begin
      if (e >= 4 * n) begin
        r.oor = 1'b1;
        return;
      end
      if (e < 2 * n) begin
        seg = e >> 1;
        base = smooth_reg ? 2 * seg : 4 * seg;
        if (!e[0]) begin
          a = base; b = base + 2; cc = base + 1;
        end else begin
          a = base + 1; b = base + 2; cc = base + 3;
        end
      end else if (e < 3 * n) begin
        seg = e - 2 * n; a = tc; b = tc + 2 + seg; cc = tc + 1 + seg;
      end else begin
        seg = e - 3 * n; a = bc; b = bc + 1 + seg; cc = bc + 2 + seg;
      end
      r.ca = 16'(a); r.cb = 16'(b); r.cc = 16'(cc);
    end
  endtask

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall: random bursts, plus a long hold-off when asked
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      if (hold_long) begin
        out_stall_i <= 1'b1;
        repeat (200) @(posedge clk_i);
        out_stall_i <= 1'b0;
        wait (!hold_long);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        k = $urandom_range(1, 9);
        repeat (k) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    elem_t w, g;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      g = {pos_x_o, pos_y_o, pos_z_o, norm_x_o, norm_y_o, norm_z_o,
           corner_a_o, corner_b_o, corner_c_o, out_of_range_o};
      if (expected_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        w = expected_q.pop_front();
        if (g.px != w.px) begin $error("pos_x exp %0d got %0d", $signed(w.px), $signed(g.px)); errors++; end
        if (g.py != w.py) begin $error("pos_y exp %0d got %0d", $signed(w.py), $signed(g.py)); errors++; end
        if (g.pz != w.pz) begin $error("pos_z exp %0d got %0d", $signed(w.pz), $signed(g.pz)); errors++; end
        if (g.nx != w.nx) begin $error("norm_x exp %0d got %0d", $signed(w.nx), $signed(g.nx)); errors++; end
        if (g.ny != w.ny) begin $error("norm_y exp %0d got %0d", $signed(w.ny), $signed(g.ny)); errors++; end
        if (g.nz != w.nz) begin $error("norm_z exp %0d got %0d", $signed(w.nz), $signed(g.nz)); errors++; end
        if (g.ca != w.ca) begin $error("corner_a exp %0d got %0d", w.ca, g.ca); errors++; end
        if (g.cb != w.cb) begin $error("corner_b exp %0d got %0d", w.cb, g.cb); errors++; end
        if (g.cc != w.cc) begin $error("corner_c exp %0d got %0d", w.cc, g.cc); errors++; end
        if (g.oor != w.oor) begin $error("out_of_range exp %0d got %0d", w.oor, g.oor); errors++; end
      end
    end
  end

  // one request beat; typed expectation used when has_exp is set
  task automatic send_request(input logic op, input logic [15:0] num,
                              input logic has_exp, input elem_t typed);
    elem_t r;
    predict_element(op, num, r);
    if (has_exp) r = typed;
    in_valid_i <= 1'b1;
    opcode_i <= op;
    element_number_i <= num;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_q.push_back(r);
    if (r.oor) n_oor++;
    else if (op == OP_VERTEX) n_vert++;
    else n_tri++;
  endtask

  task automatic sender_gap();
    int k;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      k = $urandom_range(1, 9);
      repeat (k) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  // one write beat, after which the config channel idles
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_SEGMENTS: seg_reg = val[13:0];
      REG_LENGTH:   len_reg = val;
      REG_SMOOTH:   smooth_reg = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  typedef struct {
    logic op;
    logic [15:0] num;
    logic has_exp;
    elem_t exp_r;
  } row_t;

  initial begin
    row_t rows[$];
    elem_t z, t;
    int n, cnt;
    logic op;
    logic [15:0] num;
    int vert_nums[7];
    int tri_nums[6];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset settings: N=16, length 1.0, smooth
    z = '0;
    t = z; t.oor = 1'b1;
    rows.push_back('{OP_VERTEX, 16'd70, 1'b1, t});      // first past vertex count
    rows.push_back('{OP_VERTEX, 16'hFFFF, 1'b1, t});
    rows.push_back('{OP_TRIANGLE, 16'd64, 1'b1, t});    // first past triangle count
    rows.push_back('{OP_TRIANGLE, 16'hFFFF, 1'b1, t});
    rows.push_back('{OP_VERTEX, 16'd0, 1'b0, z});        // side top at angle zero
    t = z; t.py = 16'sd128; t.ny = 16'sd16384;
    rows.push_back('{OP_VERTEX, 16'd34, 1'b1, t});       // top center
    t = z; t.py = -16'sd128; t.ny = -16'sd16384;
    rows.push_back('{OP_VERTEX, 16'd52, 1'b1, t});       // bottom center
    t = z; t.ca = 16'd0; t.cb = 16'd2; t.cc = 16'd1;
    rows.push_back('{OP_TRIANGLE, 16'd0, 1'b1, t});
    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].num, rows[i].has_exp, rows[i].exp_r);
      sender_gap();
    end
    rows.delete();
    vert_nums = '{1, 8, 33, 35, 51, 53, 69};
    tri_nums  = '{1, 31, 32, 47, 48, 63};
    foreach (vert_nums[i]) send_request(OP_VERTEX, 16'(vert_nums[i]), 1'b0, z);
    foreach (tri_nums[i]) send_request(OP_TRIANGLE, 16'(tri_nums[i]), 1'b0, z);
    drain();

    // long receiver hold-off while the sender keeps offering
    hold_long = 1'b1;
    for (int i = 0; i < 100; i++) send_request(i[0], 16'($urandom_range(0, 70)), 1'b0, z);
    hold_long = 1'b0;
    drain();

    // phases over register settings, extremes included
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin write_reg(REG_SEGMENTS, 16'd0); write_reg(REG_LENGTH, 16'd0);
                 write_reg(REG_SMOOTH, 16'd0); end
        1: begin write_reg(REG_SEGMENTS, 16'h3FFF); write_reg(REG_LENGTH, 16'hFFFF); end
        2: write_reg(REG_SMOOTH, 16'd1);
        3: begin write_reg(REG_SEGMENTS, 16'hFFFF); write_reg(REG_LENGTH, 16'hAAAA); end
        4: begin write_reg(REG_SEGMENTS, 16'd3); write_reg(REG_LENGTH, 16'h5555); end
        5: begin write_reg(REG_SEGMENTS, 16'd10923); write_reg(REG_SMOOTH, 16'd0); end
        default: begin
          write_reg(REG_SEGMENTS, 16'($urandom_range(3, 200)));
          write_reg(REG_LENGTH, 16'($urandom));
          write_reg(REG_SMOOTH, 16'($urandom_range(0, 1)));
        end
      endcase
      if (ph == 9) quiet = 1'b1;
      n = eff_segments();
      for (int i = 0; i < N_RANDOM / 10; i++) begin
        op = $urandom_range(0, 1);
        cnt = (op == OP_VERTEX) ? (smooth_reg ? 4 * n + 6 : 6 * n + 4) : 4 * n;
        case ($urandom_range(0, 9))
          0: num = 16'($urandom);
          1: num = 16'(cnt - 1 + $urandom_range(0, 2));
          default: num = 16'($urandom_range(0, cnt - 1));
        endcase
        send_request(op, num, 1'b0, z);
        sender_gap();
      end
      drain();
    end

    $display("Covered %0d vertex, %0d triangle and %0d out-of-range requests",
             n_vert, n_tri, n_oor);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
sv/cme_pkg.sv
sv/cme_front.sv
sv/cme_fifo.sv
sv/cme_back.sv
sv/cylinder_mesh_element_generator.sv
sim/tb_top.sv
